[rtl/plid_pkg.sv]
// Package for the positional list block: capacity, field widths, action and
// status codes, and the controller state type. Depends on nothing.
package plid_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int VAL_W = 32;
  localparam int POS_W = 8;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_UPDATE = 3'd2,
    ACT_READ   = 3'd3,
    ACT_DUMP   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_BAD_POS = 2'd1,
    STS_FULL    = 2'd2,
    STS_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_FIN,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_DMP_RD,
    ST_DMP_OUT,
    ST_EMIT
  } state_t;

endpackage

[rtl/plid_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Depends on nothing.
module plid_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/positional_list_insert_delete.sv]
// Top level of the positional list: request decode, shift sequencer and
// result register around one element RAM. Depends on plid_pkg and plid_ram.
//
// One request is taken at a time; in_tready is high while the sequencer is
// idle, even if a result still waits in the output register. Update, read,
// bad positions, full-list and empty-dump requests go straight to the result
// emit state; a read issues its RAM access with the accept. Insert at
// position p into a list of n entries moves each later entry through the
// single RAM read port and write port, one read state and one write state
// per entry; delete moves each later entry down through the same ports.
// Dump streams its n entries, reading each one from the RAM before its beat
// and waits while the output side stalls. The element RAM is not cleared at
// reset; only entries below the count are ever read.
module positional_list_insert_delete
  import plid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position[7:0], data_value[39:8]
  input  logic [2:0]  in_tuser,   // action[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // read_value[31:0], read_index[37:32],
                                  // list_count[44:38], zero fill[47:45]
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [VAL_W-1:0]   data_r, data_nxt;
  status_t            res_status_r, res_status_nxt;
  logic               res_mem_r, res_mem_nxt;
  logic [IDX_W-1:0]   res_index_r, res_index_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [VAL_W-1:0]   out_value_r, out_value_nxt;
  logic [IDX_W-1:0]   out_index_r, out_index_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;
  logic               out_last_r, out_last_nxt;

  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [VAL_W-1:0]   mem_wdata, mem_rdata;

  logic [POS_W-1:0]   in_pos;
  logic [VAL_W-1:0]   in_data;
  logic [POS_W-1:0]   count_ext;
  logic               out_free;

  assign in_pos    = in_tdata[7:0];
  assign in_data   = in_tdata[39:8];
  assign count_ext = {{(POS_W-CNT_W){1'b0}}, count_r};
  assign out_free  = !out_valid_r || out_tready;

  plid_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(VAL_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    data_r       <= data_nxt;
    res_status_r <= res_status_nxt;
    res_mem_r    <= res_mem_nxt;
    res_index_r  <= res_index_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_index_r  <= out_index_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    data_nxt       = data_r;
    res_status_nxt = res_status_r;
    res_mem_nxt    = res_mem_r;
    res_index_nxt  = res_index_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_index_nxt  = out_index_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = idx_r;
    in_tready      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          pos_nxt        = in_pos;
          data_nxt       = in_data;
          res_status_nxt = STS_OK;
          res_mem_nxt    = 1'b0;
          res_index_nxt  = '0;
          unique case (in_tuser)
            ACT_INSERT: begin
              if (in_pos > count_ext) begin
                res_status_nxt = STS_BAD_POS;
                state_nxt      = ST_EMIT;
              end else if (count_r == CNT_W'(CAPACITY)) begin
                res_status_nxt = STS_FULL;
                state_nxt      = ST_EMIT;
              end else if (in_pos == count_ext) begin
                state_nxt = ST_INS_FIN;
              end else begin
                idx_nxt   = count_r[IDX_W-1:0];
                state_nxt = ST_INS_RD;
              end
            end
            ACT_DELETE: begin
              if (in_pos >= count_ext) begin
                res_status_nxt = STS_BAD_POS;
                state_nxt      = ST_EMIT;
              end else begin
                idx_nxt   = in_pos[IDX_W-1:0];
                state_nxt = ST_DEL_RD;
              end
            end
            ACT_UPDATE: begin
              if (in_pos >= count_ext) begin
                res_status_nxt = STS_BAD_POS;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = in_pos[IDX_W-1:0];
                mem_wdata = in_data;
              end
              state_nxt = ST_EMIT;
            end
            ACT_READ: begin
              if (in_pos >= count_ext) begin
                res_status_nxt = STS_BAD_POS;
              end else begin
                mem_re        = 1'b1;
                mem_raddr     = in_pos[IDX_W-1:0];
                res_mem_nxt   = 1'b1;
                res_index_nxt = in_pos[IDX_W-1:0];
              end
              state_nxt = ST_EMIT;
            end
            ACT_DUMP: begin
              if (count_r == '0) begin
                res_status_nxt = STS_EMPTY;
                state_nxt      = ST_EMIT;
              end else begin
                idx_nxt   = '0;
                state_nxt = ST_DMP_RD;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_INS_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_r - IDX_W'(1);
        state_nxt = ST_INS_WR;
      end
      ST_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        idx_nxt   = idx_r - IDX_W'(1);
        if ((idx_r - IDX_W'(1)) == pos_r[IDX_W-1:0]) begin
          state_nxt = ST_INS_FIN;
        end else begin
          state_nxt = ST_INS_RD;
        end
      end
      ST_INS_FIN: begin
        mem_we         = 1'b1;
        mem_waddr      = pos_r[IDX_W-1:0];
        mem_wdata      = data_r;
        count_nxt      = count_r + CNT_W'(1);
        res_status_nxt = STS_OK;
        state_nxt      = ST_EMIT;
      end
      ST_DEL_RD: begin
        if (({1'b0, idx_r} + CNT_W'(1)) >= count_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = ST_EMIT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + IDX_W'(1);
          state_nxt = ST_DEL_WR;
        end
      end
      ST_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        idx_nxt   = idx_r + IDX_W'(1);
        state_nxt = ST_DEL_RD;
      end
      ST_DMP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_r;
        state_nxt = ST_DMP_OUT;
      end
      ST_DMP_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
          out_value_nxt  = mem_rdata;
          out_index_nxt  = idx_r;
          out_count_nxt  = count_r;
          out_last_nxt   = (({1'b0, idx_r} + CNT_W'(1)) == count_r);
          if (({1'b0, idx_r} + CNT_W'(1)) == count_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_DMP_RD;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_mem_r ? mem_rdata : '0;
          out_index_nxt  = res_index_r;
          out_count_nxt  = count_r;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_count_r, out_index_r, out_value_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list count exceeds capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) ||
                      count_r == $past(count_r) + CNT_W'(1) ||
                      count_r + CNT_W'(1) == $past(count_r)))
    else $error("list count moved by more than one");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_tdata) &&
                                      $stable(out_tlast)))
    else $error("stalled result beat was overwritten");

  a_dump_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DMP_OUT) |-> ({1'b0, idx_r} < count_r))
    else $error("dump index ran past the list count");

endmodule

[dv/tb_positional_list_insert_delete.sv]
`timescale 1ns / 100ps
// Self-checking testbench for positional_list_insert_delete: directed table, then random walks.
// Every accepted request feeds a local list model, and result beats are checked in order.
// Depends on plid_pkg and the RTL of the block.
module tb_positional_list_insert_delete
  import plid_pkg::*;
();

  localparam logic [2:0] ACT_RSV5 = 3'd5;
  localparam logic [2:0] ACT_RSV6 = 3'd6;
  localparam logic [2:0] ACT_RSV7 = 3'd7;
  localparam int RAND_ITEMS = 440;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 80;
  localparam int DIR_N = 25;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] count;
    logic             last;
  } list_beat_t;

  typedef struct packed {
    logic [2:0]       act;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic             pinned;
    list_beat_t       want;
  } dir_row_t;

  typedef enum logic [1:0] {
    WALK_FILL,
    WALK_DRAIN,
    WALK_MIX
  } walk_t;

  localparam list_beat_t NO_PIN = '0;

  // Rows with a pinned beat carry the result read straight off the behavior.
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{ACT_DUMP,   8'd0,   32'd0,          1'b1, '{STS_EMPTY,   32'd0, 6'd0, 7'd0, 1'b1}},
    '{ACT_READ,   8'd0,   32'd0,          1'b1, '{STS_BAD_POS, 32'd0, 6'd0, 7'd0, 1'b1}},
    '{ACT_DELETE, 8'd0,   32'd0,          1'b1, '{STS_BAD_POS, 32'd0, 6'd0, 7'd0, 1'b1}},
    '{ACT_UPDATE, 8'd0,   32'd1234,       1'b1, '{STS_BAD_POS, 32'd0, 6'd0, 7'd0, 1'b1}},
    '{ACT_INSERT, 8'd1,   32'd1,          1'b1, '{STS_BAD_POS, 32'd0, 6'd0, 7'd0, 1'b1}},
    '{ACT_INSERT, 8'd255, 32'd2,          1'b1, '{STS_BAD_POS, 32'd0, 6'd0, 7'd0, 1'b1}},
    '{ACT_INSERT, 8'd0,   32'h7FFF_FFFF,  1'b1, '{STS_OK,      32'd0, 6'd0, 7'd1, 1'b1}},
    '{ACT_INSERT, 8'd0,   32'h8000_0000,  1'b1, '{STS_OK,      32'd0, 6'd0, 7'd2, 1'b1}},
    '{ACT_INSERT, 8'd2,   32'hFFFF_FFFF,  1'b1, '{STS_OK,      32'd0, 6'd0, 7'd3, 1'b1}},
    '{ACT_INSERT, 8'd1,   32'd0,          1'b1, '{STS_OK,      32'd0, 6'd0, 7'd4, 1'b1}},
    '{ACT_READ,   8'd0,   32'd0,          1'b1,
      '{STS_OK, 32'h8000_0000, 6'd0, 7'd4, 1'b1}},
    '{ACT_READ,   8'd3,   32'd0,          1'b1,
      '{STS_OK, 32'hFFFF_FFFF, 6'd3, 7'd4, 1'b1}},
    '{ACT_READ,   8'd4,   32'd0,          1'b1, '{STS_BAD_POS, 32'd0, 6'd0, 7'd4, 1'b1}},
    '{ACT_UPDATE, 8'd3,   32'h5A5A_5A5A,  1'b1, '{STS_OK,      32'd0, 6'd0, 7'd4, 1'b1}},
    '{ACT_UPDATE, 8'd255, 32'd7,          1'b1, '{STS_BAD_POS, 32'd0, 6'd0, 7'd4, 1'b1}},
    '{ACT_RSV5,   8'd0,   32'd0,          1'b0, NO_PIN},
    '{ACT_DUMP,   8'd0,   32'd0,          1'b0, NO_PIN},
    '{ACT_DELETE, 8'd0,   32'd0,          1'b1, '{STS_OK,      32'd0, 6'd0, 7'd3, 1'b1}},
    '{ACT_DELETE, 8'd2,   32'd0,          1'b1, '{STS_OK,      32'd0, 6'd0, 7'd2, 1'b1}},
    '{ACT_DELETE, 8'd2,   32'd0,          1'b1, '{STS_BAD_POS, 32'd0, 6'd0, 7'd2, 1'b1}},
    '{ACT_INSERT, 8'd1,   32'hA5A5_A5A5,  1'b1, '{STS_OK,      32'd0, 6'd0, 7'd3, 1'b1}},
    '{ACT_RSV7,   8'd255, 32'hFFFF_FFFF,  1'b0, NO_PIN},
    '{ACT_DUMP,   8'd0,   32'd0,          1'b0, NO_PIN},
    '{ACT_READ,   8'd1,   32'd0,          1'b0, NO_PIN},
    '{ACT_RSV6,   8'd0,   32'd0,          1'b0, NO_PIN}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // position[7:0], data_value[39:8]
  logic [2:0]  in_tuser;   // action[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // read_value[31:0], read_index[37:32], list_count[44:38]
  logic [1:0]  out_tuser;  // status[1:0]
  logic        out_tlast;

  logic [VAL_W-1:0] list_mem [CAPACITY];
  int               list_len;
  list_beat_t       exp_beats [$];
  logic             pin_on;
  list_beat_t       pin_beat;
  int               errs;
  int               in_idle_pct;
  int               out_idle_pct;
  int               cycles;

  positional_list_insert_delete u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void list_apply(logic [2:0] act, logic [POS_W-1:0] pos,
                                     logic [VAL_W-1:0] val);
    list_beat_t b;
    int         i;
    b = '{STS_OK, 32'd0, 6'd0, 7'd0, 1'b1};
    case (act)
      ACT_INSERT: begin
        if (pos > list_len) begin
          b.status = STS_BAD_POS;
        end else if (list_len >= CAPACITY) begin
          b.status = STS_FULL;
        end else begin
          for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_len++;
        end
      end
      ACT_DELETE: begin
        if (pos >= list_len) begin
          b.status = STS_BAD_POS;
        end else begin
          for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      ACT_UPDATE: begin
        if (pos >= list_len) b.status = STS_BAD_POS;
        else list_mem[pos] = val;
      end
      ACT_READ: begin
        if (pos >= list_len) begin
          b.status = STS_BAD_POS;
        end else begin
          b.value = list_mem[pos];
          b.index = pos[IDX_W-1:0];
        end
      end
      ACT_DUMP: begin
        if (list_len == 0) b.status = STS_EMPTY;
        for (i = 0; i + 1 < list_len; i++) begin
          exp_beats.push_back('{STS_OK, list_mem[i], i[IDX_W-1:0], list_len[CNT_W-1:0], 1'b0});
        end
        if (list_len > 0) begin
          b.value = list_mem[list_len-1];
          b.index = IDX_W'(list_len - 1);
        end
      end
      default: return;
    endcase
    b.count = list_len[CNT_W-1:0];
    exp_beats.push_back(b);
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errs++;
    end
  endfunction

  function automatic void check_beat();
    list_beat_t want;
    if (exp_beats.size() == 0) begin
      $display("%0t: unexpected beat, status %0d value %h index %0d count %0d last %b",
               $time, out_tuser, out_tdata[31:0], out_tdata[37:32], out_tdata[44:38],
               out_tlast);
      errs++;
    end else begin
      want = exp_beats.pop_front();
      cmp_field("status", 32'(want.status), 32'(out_tuser));
      cmp_field("read_value", want.value, out_tdata[31:0]);
      cmp_field("read_index", 32'(want.index), 32'(out_tdata[37:32]));
      cmp_field("list_count", 32'(want.count), 32'(out_tdata[44:38]));
      cmp_field("last", 32'(want.last), 32'(out_tlast));
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        list_apply(in_tuser, in_tdata[7:0], in_tdata[39:8]);
        if (pin_on) begin
          void'(exp_beats.pop_back());
          exp_beats.push_back(pin_beat);
        end
      end
      if (out_tvalid && out_tready) check_beat();
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("[positional_list_insert_delete] ERROR");
        $finish;
      end
    end
  end

  task automatic send_request(logic [2:0] act, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                              logic pin, list_beat_t want);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    pin_on   = pin;
    pin_beat = want;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {val, pos};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin
    logic [2:0]       act;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    walk_t            walk;
    int               n_rand;
    int               full_hits;
    int               mix_left;
    int               w_ins;
    int               w_del;
    int               r;

    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    pin_on       = 1'b0;
    pin_beat     = NO_PIN;
    errs         = 0;
    list_len     = 0;
    in_idle_pct  = 10;
    out_idle_pct = 61;
    walk         = WALK_FILL;
    n_rand       = 0;
    full_hits    = 0;
    mix_left     = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < DIR_N; k++) begin
      send_request(DIR_ROWS[k].act, DIR_ROWS[k].pos, DIR_ROWS[k].val, DIR_ROWS[k].pinned,
                   DIR_ROWS[k].want);
    end

    // Fill to capacity and hit the full list, drain to empty, then mix, over and over.
    while (n_rand < RAND_ITEMS) begin
      if (n_rand == RAND_ITEMS / 3) begin
        in_idle_pct  = 61;
        out_idle_pct = 10;
      end else if (n_rand == 2 * RAND_ITEMS / 3) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      case (walk)
        WALK_FILL: begin
          if (list_len == CAPACITY) begin
            full_hits++;
            if (full_hits > 4) begin
              walk      = WALK_DRAIN;
              full_hits = 0;
            end
          end
        end
        WALK_DRAIN: begin
          if (list_len == 0) begin
            walk     = WALK_MIX;
            mix_left = $urandom_range(60, 20);
          end
        end
        default: begin
          if (mix_left == 0) walk = WALK_FILL;
          else mix_left--;
        end
      endcase
      case (walk)
        WALK_FILL: begin
          w_ins = 75;
          w_del = 5;
        end
        WALK_DRAIN: begin
          w_ins = 5;
          w_del = 75;
        end
        default: begin
          w_ins = 30;
          w_del = 25;
        end
      endcase
      r = $urandom_range(99);
      if (r < w_ins) begin
        act = ACT_INSERT;
      end else if (r < w_ins + w_del) begin
        act = ACT_DELETE;
      end else if (r < 97) begin
        case ($urandom_range(2))
          0: act = ACT_UPDATE;
          1: act = ACT_READ;
          default: act = ACT_DUMP;
        endcase
      end else begin
        case ($urandom_range(2))
          0: act = ACT_RSV5;
          1: act = ACT_RSV6;
          default: act = ACT_RSV7;
        endcase
      end
      if ($urandom_range(99) < 12) pos = $urandom_range(255);
      else if (act == ACT_INSERT) pos = $urandom_range(list_len, 0);
      else if (list_len > 0) pos = $urandom_range(list_len - 1, 0);
      else pos = $urandom_range(3);
      case ($urandom_range(19))
        0: val = 32'h8000_0000;
        1: val = 32'h7FFF_FFFF;
        2: val = 32'hFFFF_FFFF;
        3: val = 32'd0;
        default: val = $urandom();
      endcase
      send_request(act, pos, val, 1'b0, NO_PIN);
      if (act <= ACT_DUMP) n_rand++;
    end
    in_tvalid <= 1'b0;

    while (exp_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errs == 0) begin
      $display("[positional_list_insert_delete] OK");
    end else begin
      $display("[positional_list_insert_delete] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/plid_pkg.sv
rtl/plid_ram.sv
rtl/positional_list_insert_delete.sv
dv/tb_positional_list_insert_delete.sv
